[design/lvrs_pkg.sv]
// Shared types and constants for the linear volume request splitter.
// Used by lvrs_cfg_regs, lvrs_alu and linear_volume_request_splitter.
package lvrs_pkg;

    // Widest configuration that the splitter handles
    localparam logic [2:0] MAX_MEMBERS = 3'd4;

    // Operation codes
    localparam logic [2:0] OP_IO      = 3'd0;
    localparam logic [2:0] OP_DISCARD = 3'd1;
    localparam logic [2:0] OP_ZEROS   = 3'd2;
    localparam logic [2:0] OP_META    = 3'd3;
    localparam logic [2:0] OP_SIMPLE  = 3'd4;
    localparam logic [2:0] OP_FLUSH   = 3'd5;

    // Result status codes
    localparam logic [2:0] ST_SEG     = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_NOTOPEN = 3'd2;
    localparam logic [2:0] ST_IOERR   = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_MEMBER_COUNT = 3'd0;
    localparam logic [2:0] REG_OPENED_MASK  = 3'd1;
    localparam logic [2:0] REG_TOTAL_LENGTH = 3'd2;
    localparam logic [2:0] REG_END_ADDR_0   = 3'd3;
    localparam logic [2:0] REG_END_ADDR_1   = 3'd4;
    localparam logic [2:0] REG_END_ADDR_2   = 3'd5;
    localparam logic [2:0] REG_END_ADDR_3   = 3'd6;

    // Input beat
    typedef struct packed {
        logic [2:0]  operation;
        logic        direction;
        logic [47:0] start_address;
        logic [47:0] byte_count;
        logic [31:0] buffer_offset;
        logic [15:0] request_tag;
    } t_req;

    // Output beat
    typedef struct packed {
        logic [2:0]  result_status;
        logic [1:0]  member_index;
        logic [47:0] member_address;
        logic [47:0] segment_bytes;
        logic [31:0] segment_offset;
        logic [2:0]  segment_operation;
        logic        segment_direction;
        logic [15:0] result_tag;
        logic        last_result;
    } t_res;

    // Live configuration seen by the sequencer
    typedef struct packed {
        logic [2:0]       members;
        logic [3:0]       opened;
        logic [47:0]      total;
        logic [3:0][47:0] member_end;
    } t_cfg;

    // Request to the shared add/subtract unit
    typedef struct packed {
        logic        sub;
        logic [48:0] a;
        logic [48:0] b;
    } t_alu_op;

endpackage

[design/linear_volume_request_splitter.sv]
// Top level of the linear volume request splitter: sequencer and output register.
// Depends on lvrs_pkg, lvrs_cfg_regs and lvrs_alu.
//
// Usage: a request beat enters on i_in_valid/o_in_stall and is split into one
// segment beat per member volume it touches, followed by exactly one
// completion beat (last_result set) on o_out_valid/i_out_stall. Configuration
// is written through i_cfg_we/i_cfg_idx/i_cfg_data while no request is open.
// Throughput: one request at a time; o_in_stall is high from the accepting
// edge until the completion beat is loaded into the output register. The
// range, member search and segment arithmetic goes through one shared 49-bit
// add/subtract unit, one operation per cycle: a range request runs the range
// checks, the member search, setup, then the length, clip, output and
// next-member steps for each segment, and the completion. Buffer offsets and
// the member counter use their own adders.
// Reset clears the sequencer, the output valid and all configuration
// registers to zero. A stalled receiver holds the output beat; the sequencer
// waits on each further beat, and the next request is taken while the
// completion beat of the previous one still waits.
module linear_volume_request_splitter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  lvrs_pkg::t_req  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output lvrs_pkg::t_res  o_out_data,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [47:0]     i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_SUM, S_RANGE_LO, S_RANGE_HI, S_FIND, S_CHECK, S_SIMPLE_FIT,
        S_MADDR, S_SEG_LEN, S_SEG_MIN, S_SEG_OUT, S_NEXT, S_FLUSH, S_DONE
    } t_state;

    t_state            r_state;
    lvrs_pkg::t_req    r_req;
    lvrs_pkg::t_res    r_out;
    logic              r_out_valid;
    logic [2:0]        r_idx;
    logic              r_found;
    logic [48:0]       r_sum;
    logic [47:0]       r_caddr;
    logic [47:0]       r_rem;
    logic [47:0]       r_maddr;
    logic [47:0]       r_seg;
    logic [31:0]       r_off;
    logic [2:0]        r_status;

    lvrs_pkg::t_cfg    cfg;
    lvrs_pkg::t_alu_op alu_op;
    logic [49:0]       alu_res;
    logic              alu_borrow;
    logic              out_free;
    logic              out_load;
    logic              idx_end;
    logic              idx_open;
    logic              moves;
    logic              simple;
    logic [47:0]       end_cur;
    logic [47:0]       end_prev;

    lvrs_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lvrs_alu u_alu (
        .i_op  (alu_op),
        .o_res (alu_res)
    );

    // Decode the current member and request kind
    always_comb begin
        out_free   = !r_out_valid || !i_out_stall;
        idx_end    = (r_idx >= cfg.members);
        out_load   = out_free && ((r_state == S_SEG_OUT) || (r_state == S_DONE) ||
                                  ((r_state == S_FLUSH) && !idx_end));
        idx_open   = cfg.opened[r_idx[1:0]];
        end_cur    = cfg.member_end[r_idx[1:0]];
        end_prev   = (r_idx == 3'd0) ? 48'd0 : cfg.member_end[r_idx[1:0] - 2'd1];
        moves      = (r_req.operation == lvrs_pkg::OP_IO) ||
                     (r_req.operation == lvrs_pkg::OP_META);
        simple     = (r_req.operation == lvrs_pkg::OP_SIMPLE);
        alu_borrow = alu_res[49];
    end

    // Steer the shared unit by sequencer step
    always_comb begin
        alu_op = '0;
        case (r_state)
            S_SUM: begin
                alu_op.a = {1'b0, r_req.start_address};
                alu_op.b = {1'b0, r_req.byte_count};
            end
            S_RANGE_LO: begin
                alu_op.sub = 1'b1;
                alu_op.a   = {1'b0, r_req.start_address};
                alu_op.b   = {1'b0, cfg.total};
            end
            S_RANGE_HI: begin
                alu_op.sub = 1'b1;
                alu_op.a   = {1'b0, cfg.total};
                alu_op.b   = r_sum;
            end
            S_FIND: begin
                alu_op.sub = 1'b1;
                alu_op.a   = {1'b0, r_req.start_address};
                alu_op.b   = {1'b0, end_cur};
            end
            S_SIMPLE_FIT: begin
                alu_op.sub = 1'b1;
                alu_op.a   = {1'b0, end_cur};
                alu_op.b   = r_sum;
            end
            S_MADDR: begin
                alu_op.sub = 1'b1;
                alu_op.a   = {1'b0, r_req.start_address};
                alu_op.b   = {1'b0, end_prev};
            end
            S_SEG_LEN: begin
                alu_op.sub = 1'b1;
                alu_op.a   = {1'b0, end_cur};
                alu_op.b   = {1'b0, r_caddr};
            end
            S_SEG_MIN: begin
                alu_op.sub = 1'b1;
                alu_op.a   = {1'b0, r_rem};
                alu_op.b   = {1'b0, r_seg};
            end
            default: begin
            end
        endcase
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= 3'd0;
        end else begin
            // Load a new output beat, or drop the current one once taken
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req <= i_in_data;
                        r_idx <= 3'd0;
                        if (i_in_data.operation > lvrs_pkg::OP_FLUSH) begin
                            r_status <= lvrs_pkg::ST_IOERR;
                            r_state  <= S_DONE;
                        end else if (i_in_data.operation == lvrs_pkg::OP_FLUSH) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_state <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    r_sum   <= alu_res[48:0];
                    r_state <= S_RANGE_LO;
                end
                S_RANGE_LO: begin
                    if (!alu_borrow) begin
                        r_status <= lvrs_pkg::ST_RANGE;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_RANGE_HI;
                    end
                end
                S_RANGE_HI: begin
                    if (alu_borrow) begin
                        r_status <= lvrs_pkg::ST_RANGE;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_FIND;
                    end
                end
                // Scan members for the first end above the start address
                S_FIND: begin
                    if (idx_end) begin
                        r_found <= 1'b0;
                        r_state <= S_CHECK;
                    end else if (alu_borrow) begin
                        r_found <= 1'b1;
                        r_state <= S_CHECK;
                    end else begin
                        r_idx <= r_idx + 3'd1;
                    end
                end
                S_CHECK: begin
                    if (simple) begin
                        if (!r_found || !idx_open) begin
                            r_status <= lvrs_pkg::ST_IOERR;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_SIMPLE_FIT;
                        end
                    end else if (!r_found) begin
                        r_status <= lvrs_pkg::ST_OK;
                        r_state  <= S_DONE;
                    end else if (!idx_open) begin
                        r_status <= lvrs_pkg::ST_NOTOPEN;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_MADDR;
                    end
                end
                S_SIMPLE_FIT: begin
                    if (alu_borrow) begin
                        r_status <= lvrs_pkg::ST_IOERR;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_MADDR;
                    end
                end
                S_MADDR: begin
                    r_maddr <= alu_res[47:0];
                    r_caddr <= r_req.start_address;
                    r_rem   <= r_req.byte_count;
                    r_off   <= r_req.buffer_offset;
                    if (simple) begin
                        r_seg   <= r_req.byte_count;
                        r_state <= S_SEG_OUT;
                    end else if (r_req.byte_count == 48'd0) begin
                        r_status <= lvrs_pkg::ST_OK;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_SEG_LEN;
                    end
                end
                S_SEG_LEN: begin
                    r_seg   <= alu_res[47:0];
                    r_state <= S_SEG_MIN;
                end
                // Clip the segment to the bytes left
                S_SEG_MIN: begin
                    if (alu_borrow) begin
                        r_seg <= r_rem;
                        r_rem <= 48'd0;
                    end else begin
                        r_rem <= alu_res[47:0];
                    end
                    r_state <= S_SEG_OUT;
                end
                S_SEG_OUT: begin
                    if (out_free) begin
                        r_out.result_status        <= lvrs_pkg::ST_SEG;
                        r_out.member_index         <= r_idx[1:0];
                        r_out.member_address       <= r_maddr;
                        r_out.segment_bytes        <= r_seg;
                        r_out.segment_offset       <= moves ? r_off : 32'd0;
                        r_out.segment_operation    <= r_req.operation;
                        r_out.segment_direction    <= r_req.direction;
                        r_out.result_tag           <= r_req.request_tag;
                        r_out.last_result          <= 1'b0;
                        if (simple) begin
                            r_status <= lvrs_pkg::ST_OK;
                            r_state  <= S_DONE;
                        end else begin
                            r_off   <= r_off + r_seg[31:0];
                            r_maddr <= 48'd0;
                            r_caddr <= end_cur;
                            r_idx   <= r_idx + 3'd1;
                            r_state <= S_NEXT;
                        end
                    end
                end
                S_NEXT: begin
                    if (idx_end || (r_rem == 48'd0)) begin
                        r_status <= lvrs_pkg::ST_OK;
                        r_state  <= S_DONE;
                    end else if (!idx_open) begin
                        r_status <= lvrs_pkg::ST_NOTOPEN;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_SEG_LEN;
                    end
                end
                // One empty segment per configured member
                S_FLUSH: begin
                    if (idx_end) begin
                        r_status <= lvrs_pkg::ST_OK;
                        r_state  <= S_DONE;
                    end else if (out_free) begin
                        r_out.result_status        <= lvrs_pkg::ST_SEG;
                        r_out.member_index         <= r_idx[1:0];
                        r_out.member_address       <= 48'd0;
                        r_out.segment_bytes        <= 48'd0;
                        r_out.segment_offset       <= 32'd0;
                        r_out.segment_operation    <= r_req.operation;
                        r_out.segment_direction    <= r_req.direction;
                        r_out.result_tag           <= r_req.request_tag;
                        r_out.last_result          <= 1'b0;
                        r_idx                      <= r_idx + 3'd1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out.result_status        <= r_status;
                        r_out.member_index         <= 2'd0;
                        r_out.member_address       <= 48'd0;
                        r_out.segment_bytes        <= 48'd0;
                        r_out.segment_offset       <= 32'd0;
                        r_out.segment_operation    <= r_req.operation;
                        r_out.segment_direction    <= r_req.direction;
                        r_out.result_tag           <= r_req.request_tag;
                        r_out.last_result          <= 1'b1;
                        r_state                    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Every beat but the completion is a segment
    a_mid_is_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last_result |->
            o_out_data.result_status == lvrs_pkg::ST_SEG)
        else $error("non-final beat is not a segment");

    // An accepted request closes the input until it completes
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input reopened right after a request beat");

    // Member counter never runs past the member limit
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= lvrs_pkg::MAX_MEMBERS)
        else $error("member counter out of bounds");

    // Discard and write-zeros segments carry no buffer offset
    a_no_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.result_status == lvrs_pkg::ST_SEG) &&
        ((o_out_data.segment_operation == lvrs_pkg::OP_DISCARD) ||
         (o_out_data.segment_operation == lvrs_pkg::OP_ZEROS)) |->
            o_out_data.segment_offset == 32'd0)
        else $error("offset on a discard or write-zeros segment");

endmodule

[design/lvrs_cfg_regs.sv]
// Configuration register file of the request splitter.
// Depends on lvrs_pkg for the register indexes and the t_cfg struct.
module lvrs_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [47:0]       i_cfg_data,
    output lvrs_pkg::t_cfg    o_cfg
);

    lvrs_pkg::t_cfg r_cfg;

    // Write one register per beat; saturate the member count on the way in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lvrs_pkg::REG_MEMBER_COUNT: begin
                    r_cfg.members <= (i_cfg_data[2:0] > lvrs_pkg::MAX_MEMBERS) ?
                                     lvrs_pkg::MAX_MEMBERS : i_cfg_data[2:0];
                end
                lvrs_pkg::REG_OPENED_MASK:  r_cfg.opened        <= i_cfg_data[3:0];
                lvrs_pkg::REG_TOTAL_LENGTH: r_cfg.total         <= i_cfg_data;
                lvrs_pkg::REG_END_ADDR_0:   r_cfg.member_end[0] <= i_cfg_data;
                lvrs_pkg::REG_END_ADDR_1:   r_cfg.member_end[1] <= i_cfg_data;
                lvrs_pkg::REG_END_ADDR_2:   r_cfg.member_end[2] <= i_cfg_data;
                lvrs_pkg::REG_END_ADDR_3:   r_cfg.member_end[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[design/lvrs_alu.sv]
// Shared 49-bit add/subtract unit of the request splitter.
// Depends on lvrs_pkg for t_alu_op; bit 49 of a difference is the borrow.
module lvrs_alu (
    input  lvrs_pkg::t_alu_op i_op,
    output logic [49:0]       o_res
);

    logic [49:0] b_ext;

    // Invert and carry in one for a subtract
    always_comb begin
        b_ext = {1'b0, i_op.b} ^ {50{i_op.sub}};
        o_res = {1'b0, i_op.a} + b_ext + {49'd0, i_op.sub};
    end

endmodule
